[sv/rtc3w_pkg.sv]
// ----------------------------------------------------------------------------
// rtc3w_pkg: shared types and constants
// Request codes, sequencer phases, payload structs and burst sizing for the
// three-wire serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

	// Number of data bytes moved by one burst transaction.
	localparam int BURST_BYTES = 8;
	localparam int BUF_DEPTH   = 8;
	localparam int BUF_AW      = 3;
	// Byte counter must reach BURST_BYTES and still give a 3-bit read index.
	localparam int BC_W = ($clog2(BURST_BYTES + 1) > BUF_AW) ?
		$clog2(BURST_BYTES + 1) : BUF_AW;

	localparam logic [7:0] CMD_WR_BASE = 8'h80;
	localparam logic [7:0] CMD_RD_BASE = 8'h81;
	localparam logic [7:0] CMD_BWR     = 8'hBE;
	localparam logic [7:0] CMD_BRD     = 8'hBF;

	typedef enum logic [2:0] {
		REQ_TICK = 3'd0,
		REQ_SWR  = 3'd1,
		REQ_SRD  = 3'd2,
		REQ_BWR  = 3'd3,
		REQ_BRD  = 3'd4,
		REQ_LOAD = 3'd5
	} req_code_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_CMD  = 3'd1,
		PH_WR   = 3'd2,
		PH_RD   = 3'd3,
		PH_END  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MD_SWR = 2'd0,
		MD_SRD = 2'd1,
		MD_BWR = 2'd2,
		MD_BRD = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [5:0] reg_addr;
		logic [7:0] wr_data;
		logic [2:0] buf_index;
		logic       io_in;
	} req_t;

	typedef struct packed {
		logic       ce_level;
		logic       sclk_level;
		logic       io_out;
		logic       io_drive;
		logic       busy_res;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic [2:0] rd_index;
		logic       done_res;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

endpackage

[sv/rtc3w_if.sv]
// ----------------------------------------------------------------------------
// rtc3w_if: request and result channels
// Valid/ready channel interfaces carrying the request and result payloads.
// ----------------------------------------------------------------------------
interface rtc3w_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [5:0] reg_addr;
	logic [7:0] wr_data;
	logic [2:0] buf_index;
	logic       io_in;

	modport source (output valid, req_type, reg_addr, wr_data, buf_index, io_in,
		input ready);
	modport sink (input valid, req_type, reg_addr, wr_data, buf_index, io_in,
		output ready);
endinterface

interface rtc3w_res_if;
	logic       valid;
	logic       ready;
	logic       ce_level;
	logic       sclk_level;
	logic       io_out;
	logic       io_drive;
	logic       busy_res;
	logic       rd_valid;
	logic [7:0] rd_data;
	logic [2:0] rd_index;
	logic       done_res;
	logic       rejected;

	modport source (output valid, ce_level, sclk_level, io_out, io_drive, busy_res,
		rd_valid, rd_data, rd_index, done_res, rejected, input ready);
	modport sink (input valid, ce_level, sclk_level, io_out, io_drive, busy_res,
		rd_valid, rd_data, rd_index, done_res, rejected, output ready);
endinterface

[sv/rtc3w_buf.sv]
// ----------------------------------------------------------------------------
// rtc3w_buf: burst data buffer
// Eight byte entries loaded by the host and read by the sequencer.
// ----------------------------------------------------------------------------
module rtc3w_buf (
	input  logic                         clk,
	input  rtc3w_pkg::buf_wr_t           wr,
	input  logic [rtc3w_pkg::BUF_AW-1:0] rd_addr,
	output logic [7:0]                   rd_data
);

	logic [7:0] mem_q [rtc3w_pkg::BUF_DEPTH];
	logic [7:0] rd_data_q;

	// Read data is registered from the address.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Contents are never valid before a load, so no reset is needed.
	assign rd_data = rd_data_q;

endmodule

[sv/rtc3w_seq.sv]
// ----------------------------------------------------------------------------
// rtc3w_seq: transaction sequencer
// Holds the bit-level state and computes one waveform tick per request.
// ----------------------------------------------------------------------------
module rtc3w_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  rtc3w_pkg::req_t              req,
	input  logic [7:0]                   buf_rd_data,
	output logic [rtc3w_pkg::BUF_AW-1:0] buf_rd_addr,
	output rtc3w_pkg::buf_wr_t           buf_wr,
	output rtc3w_pkg::res_t              res
);

	rtc3w_pkg::phase_t           phase_q, phase_d;
	rtc3w_pkg::mode_t            mode_q, mode_d;
	logic [2:0]                  bit_cnt_q, bit_cnt_d;
	logic [rtc3w_pkg::BC_W-1:0]  byte_cnt_q, byte_cnt_d, byte_cnt_inc;
	logic [7:0]                  shift_q, shift_d;
	logic [7:0]                  single_q, single_d;
	logic                        sclk_q, sclk_d;
	logic                        is_request;
	logic                        is_burst;
	logic                        last_byte;
	logic [7:0]                  rd_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rtc3w_pkg::PH_IDLE;
			mode_q     <= rtc3w_pkg::MD_SWR;
			bit_cnt_q  <= '0;
			byte_cnt_q <= '0;
			shift_q    <= '0;
			single_q   <= '0;
			sclk_q     <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			mode_q     <= mode_d;
			bit_cnt_q  <= bit_cnt_d;
			byte_cnt_q <= byte_cnt_d;
			shift_q    <= shift_d;
			single_q   <= single_d;
			sclk_q     <= sclk_d;
		end
	end

	assign is_request = (req.req_type >= rtc3w_pkg::REQ_SWR) &&
		(req.req_type <= rtc3w_pkg::REQ_LOAD);
	assign is_burst = (mode_q == rtc3w_pkg::MD_BWR) || (mode_q == rtc3w_pkg::MD_BRD);
	assign byte_cnt_inc = byte_cnt_q + 1'b1;
	assign last_byte = !is_burst ||
		(byte_cnt_inc >= rtc3w_pkg::BC_W'(rtc3w_pkg::BURST_BYTES));
	assign rd_shift = shift_q | (8'(req.io_in) << bit_cnt_q);
	// The command phase fetches entry zero; later bytes fetch the next entry.
	assign buf_rd_addr = (phase_q == rtc3w_pkg::PH_CMD) ? '0 :
		byte_cnt_inc[rtc3w_pkg::BUF_AW-1:0];

	always_comb begin
		phase_d    = phase_q;
		mode_d     = mode_q;
		bit_cnt_d  = bit_cnt_q;
		byte_cnt_d = byte_cnt_q;
		shift_d    = shift_q;
		single_d   = single_q;
		sclk_d     = sclk_q;
		buf_wr     = '{en: 1'b0, addr: req.buf_index, data: req.wr_data};
		res        = '0;

		case (phase_q)
			rtc3w_pkg::PH_IDLE: begin
				if (req.req_type == rtc3w_pkg::REQ_LOAD) begin
					buf_wr.en = 1'b1;
				end else if (is_request) begin
					mode_d     = rtc3w_pkg::mode_t'(req.req_type[1:0] - 2'd1);
					bit_cnt_d  = '0;
					byte_cnt_d = '0;
					sclk_d     = 1'b0;
					phase_d    = rtc3w_pkg::PH_CMD;
					res.ce_level = 1'b1;
					case (req.req_type)
						rtc3w_pkg::REQ_SWR: begin
							shift_d  = {1'b0, req.reg_addr, 1'b0} | rtc3w_pkg::CMD_WR_BASE;
							single_d = req.wr_data;
						end
						rtc3w_pkg::REQ_SRD: begin
							shift_d = {1'b0, req.reg_addr, 1'b0} | rtc3w_pkg::CMD_RD_BASE;
						end
						rtc3w_pkg::REQ_BWR: begin
							shift_d = rtc3w_pkg::CMD_BWR;
						end
						default: begin
							shift_d = rtc3w_pkg::CMD_BRD;
						end
					endcase
				end
			end
			rtc3w_pkg::PH_END: begin
				res.rejected = is_request;
				phase_d      = rtc3w_pkg::PH_IDLE;
				sclk_d       = 1'b0;
				res.done_res = 1'b1;
			end
			rtc3w_pkg::PH_CMD, rtc3w_pkg::PH_WR: begin
				res.rejected = is_request;
				res.ce_level = 1'b1;
				res.io_drive = 1'b1;
				res.io_out   = shift_q[0];
				if (!sclk_q) begin
					sclk_d = 1'b1;
				end else begin
					sclk_d  = 1'b0;
					shift_d = shift_q >> 1;
					if (bit_cnt_q == 3'd7) begin
						bit_cnt_d = '0;
						if (phase_q == rtc3w_pkg::PH_CMD) begin
							byte_cnt_d = '0;
							if (mode_q == rtc3w_pkg::MD_SWR) begin
								phase_d = rtc3w_pkg::PH_WR;
								shift_d = single_q;
							end else if (mode_q == rtc3w_pkg::MD_BWR) begin
								phase_d = rtc3w_pkg::PH_WR;
								shift_d = buf_rd_data;
							end else begin
								phase_d = rtc3w_pkg::PH_RD;
								shift_d = '0;
							end
						end else begin
							byte_cnt_d = byte_cnt_inc;
							if (last_byte) begin
								phase_d = rtc3w_pkg::PH_END;
							end else begin
								shift_d = buf_rd_data;
							end
						end
					end else begin
						bit_cnt_d = bit_cnt_q + 3'd1;
					end
				end
			end
			default: begin
				// Read phase: sample the pin ahead of the rising edge.
				res.rejected = is_request;
				res.ce_level = 1'b1;
				if (!sclk_q) begin
					shift_d = rd_shift;
					sclk_d  = 1'b1;
				end else begin
					sclk_d = 1'b0;
					if (bit_cnt_q == 3'd7) begin
						bit_cnt_d    = '0;
						res.rd_valid = 1'b1;
						res.rd_data  = shift_q;
						res.rd_index = byte_cnt_q[2:0];
						byte_cnt_d   = byte_cnt_inc;
						shift_d      = '0;
						if (last_byte) begin
							phase_d = rtc3w_pkg::PH_END;
						end
					end else begin
						bit_cnt_d = bit_cnt_q + 3'd1;
					end
				end
			end
		endcase

		res.sclk_level = sclk_d;
		res.busy_res   = (phase_d != rtc3w_pkg::PH_IDLE);
	end

endmodule

[sv/three_wire_rtc_serial_master.sv]
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master: three-wire real-time-clock serial master
// Bit-banged CE/SCLK/IO master advanced one waveform tick per request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake    Carries
//   -------  ---------  -----------  ------------------------------------------
//   item     in         valid/ready  request code, address, data, index, io pin
//   result   out        valid/ready  pin levels, busy, read byte, done, reject
//
// Every request transaction produces exactly one result transaction, registered
// in the output stage. A new request is accepted in every cycle in which the
// output stage is empty or is being emptied, so while the result side keeps up
// the sustained rate is one transaction per cycle. A stall on the result side
// holds the output stage and blocks the request side only while it is full.
// Reset clears the sequencer and the output valid flag at once; the burst
// buffer holds no defined data until the host loads it.
//
// A transaction on the serial link spans many requests: one to raise CE, two
// for each bit of the command byte and of every data byte, and one more to
// drop CE and report completion. Start and load requests that arrive while a
// link transaction is running are flagged as rejected, but still advance
// the waveform as a plain tick.
module three_wire_rtc_serial_master (
	input  logic        clk,
	input  logic        arst_n,
	rtc3w_req_if.sink   item,
	rtc3w_res_if.source result
);

	rtc3w_pkg::req_t                  req;
	rtc3w_pkg::res_t                  res_next;
	rtc3w_pkg::res_t                  res_q;
	rtc3w_pkg::buf_wr_t               buf_wr;
	rtc3w_pkg::buf_wr_t               buf_wr_gated;
	logic [rtc3w_pkg::BUF_AW-1:0]     buf_rd_addr;
	logic [7:0]                       buf_rd_data;
	logic                             out_valid_q;
	logic                             step;

	// Accept whenever the output stage will have room at this edge.
	assign item.ready = !out_valid_q || result.ready;
	assign step       = item.valid && item.ready;

	assign req = '{
		req_type:  item.req_type,
		reg_addr:  item.reg_addr,
		wr_data:   item.wr_data,
		buf_index: item.buf_index,
		io_in:     item.io_in
	};

	assign buf_wr_gated = '{en: buf_wr.en && step, addr: buf_wr.addr, data: buf_wr.data};

	// The buffer read is registered. The entry for the next data byte is addressed
	// during the whole byte before it, so the data is settled by the tick that
	// loads it into the shifter.
	rtc3w_buf u_buf (
		.clk     (clk),
		.wr      (buf_wr_gated),
		.rd_addr (buf_rd_addr),
		.rd_data (buf_rd_data)
	);

	rtc3w_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req         (req),
		.buf_rd_data (buf_rd_data),
		.buf_rd_addr (buf_rd_addr),
		.buf_wr      (buf_wr),
		.res         (res_next)
	);

	// Output stage: valid is control state, the payload is loaded on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_next;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.ce_level   = res_q.ce_level;
	assign result.sclk_level = res_q.sclk_level;
	assign result.io_out     = res_q.io_out;
	assign result.io_drive   = res_q.io_drive;
	assign result.busy_res   = res_q.busy_res;
	assign result.rd_valid   = res_q.rd_valid;
	assign result.rd_data    = res_q.rd_data;
	assign result.rd_index   = res_q.rd_index;
	assign result.done_res   = res_q.done_res;
	assign result.rejected   = res_q.rejected;

endmodule

[sim/rtc3w_link_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc3w_link_checker: result predictor and scoreboard
// Watches both channels of the three-wire serial master, predicts the pin
// levels and read bytes for every accepted request and compares each result.
// ----------------------------------------------------------------------------
module rtc3w_link_checker (
	input  logic clk,
	input  logic arst_n,
	rtc3w_req_if item,
	rtc3w_res_if result,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   read_bytes,
	output int   finished,
	output int   refused
);

	// Shadow copy of the serial sequencer.
	rtc3w_pkg::phase_t link_phase;
	rtc3w_pkg::mode_t  link_mode;
	logic [2:0]        bit_pos;
	int unsigned       byte_num;
	logic [7:0]        shifter;
	logic [7:0]        single_byte;
	logic [7:0]        burst_buf [rtc3w_pkg::BUF_DEPTH];
	logic              sclk_q;

	rtc3w_pkg::res_t tick_outcomes [$];

	int n_fail    = 0;
	int n_checked = 0;
	int n_rd      = 0;
	int n_done    = 0;
	int n_rej     = 0;

	assign fail_count = n_fail;
	assign checked    = n_checked;
	assign read_bytes = n_rd;
	assign finished   = n_done;
	assign refused    = n_rej;

	function automatic logic at_last_byte();
		return (link_mode == rtc3w_pkg::MD_SWR) || (link_mode == rtc3w_pkg::MD_SRD) ||
			(byte_num >= rtc3w_pkg::BURST_BYTES);
	endfunction

	// Advances the shadow sequencer by one tick and returns the pin levels it implies.
	function automatic rtc3w_pkg::res_t advance_link(input rtc3w_pkg::req_t rq);
		rtc3w_pkg::res_t r;
		logic asks;
		r = '0;
		asks = (rq.req_type >= rtc3w_pkg::REQ_SWR) && (rq.req_type <= rtc3w_pkg::REQ_LOAD);
		if (link_phase == rtc3w_pkg::PH_IDLE) begin
			if (rq.req_type == rtc3w_pkg::REQ_LOAD) begin
				burst_buf[rq.buf_index] = rq.wr_data;
			end else if (asks) begin
				bit_pos    = '0;
				byte_num   = 0;
				sclk_q     = 1'b0;
				link_phase = rtc3w_pkg::PH_CMD;
				r.ce_level = 1'b1;
				case (rq.req_type)
					rtc3w_pkg::REQ_SWR: begin
						link_mode   = rtc3w_pkg::MD_SWR;
						shifter     = {1'b0, rq.reg_addr, 1'b0} | rtc3w_pkg::CMD_WR_BASE;
						single_byte = rq.wr_data;
					end
					rtc3w_pkg::REQ_SRD: begin
						link_mode = rtc3w_pkg::MD_SRD;
						shifter   = {1'b0, rq.reg_addr, 1'b0} | rtc3w_pkg::CMD_RD_BASE;
					end
					rtc3w_pkg::REQ_BWR: begin
						link_mode = rtc3w_pkg::MD_BWR;
						shifter   = rtc3w_pkg::CMD_BWR;
					end
					default: begin
						link_mode = rtc3w_pkg::MD_BRD;
						shifter   = rtc3w_pkg::CMD_BRD;
					end
				endcase
			end
		end else begin
			// Busy: requests are refused but the tick still moves the waveform.
			r.rejected = asks;
			case (link_phase)
				rtc3w_pkg::PH_END: begin
					link_phase = rtc3w_pkg::PH_IDLE;
					sclk_q     = 1'b0;
					r.done_res = 1'b1;
				end
				rtc3w_pkg::PH_CMD, rtc3w_pkg::PH_WR: begin
					r.ce_level = 1'b1;
					r.io_drive = 1'b1;
					r.io_out   = shifter[0];
					if (!sclk_q) begin
						sclk_q = 1'b1;
					end else begin
						sclk_q  = 1'b0;
						shifter = shifter >> 1;
						if (bit_pos == 3'd7) begin
							bit_pos = '0;
							if (link_phase == rtc3w_pkg::PH_CMD) begin
								byte_num = 0;
								case (link_mode)
									rtc3w_pkg::MD_SWR: begin
										link_phase = rtc3w_pkg::PH_WR;
										shifter    = single_byte;
									end
									rtc3w_pkg::MD_BWR: begin
										link_phase = rtc3w_pkg::PH_WR;
										shifter    = burst_buf[0];
									end
									default: begin
										link_phase = rtc3w_pkg::PH_RD;
										shifter    = '0;
									end
								endcase
							end else begin
								byte_num++;
								if (at_last_byte())
									link_phase = rtc3w_pkg::PH_END;
								else
									shifter = burst_buf[byte_num % rtc3w_pkg::BUF_DEPTH];
							end
						end else begin
							bit_pos++;
						end
					end
				end
				default: begin
					// Read: the pin is sampled on the tick that raises SCLK.
					r.ce_level = 1'b1;
					if (!sclk_q) begin
						shifter[bit_pos] = shifter[bit_pos] | rq.io_in;
						sclk_q = 1'b1;
					end else begin
						sclk_q = 1'b0;
						if (bit_pos == 3'd7) begin
							bit_pos    = '0;
							r.rd_valid = 1'b1;
							r.rd_data  = shifter;
							r.rd_index = byte_num[rtc3w_pkg::BUF_AW-1:0];
							byte_num++;
							shifter = '0;
							if (at_last_byte())
								link_phase = rtc3w_pkg::PH_END;
						end else begin
							bit_pos++;
						end
					end
				end
			endcase
		end
		r.sclk_level = sclk_q;
		r.busy_res   = (link_phase != rtc3w_pkg::PH_IDLE);
		return r;
	endfunction

	function automatic string show(input rtc3w_pkg::res_t r);
		return {$sformatf("ce=%0b sclk=%0b io=%0b drv=%0b busy=%0b ",
				r.ce_level, r.sclk_level, r.io_out, r.io_drive, r.busy_res),
			$sformatf("rv=%0b rd=%02h idx=%0d done=%0b rej=%0b",
				r.rd_valid, r.rd_data, r.rd_index, r.done_res, r.rejected)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rtc3w_pkg::res_t got;
		rtc3w_pkg::res_t want;
		rtc3w_pkg::req_t rq;
		if (!arst_n) begin
			link_phase  = rtc3w_pkg::PH_IDLE;
			link_mode   = rtc3w_pkg::MD_SWR;
			bit_pos     = '0;
			byte_num    = 0;
			shifter     = '0;
			single_byte = '0;
			sclk_q      = 1'b0;
			foreach (burst_buf[i])
				burst_buf[i] = '0;
			tick_outcomes.delete();
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.ce_level, result.sclk_level, result.io_out, result.io_drive,
					result.busy_res, result.rd_valid, result.rd_data, result.rd_index,
					result.done_res, result.rejected};
				n_checked++;
				if (tick_outcomes.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("%t: result with nothing expected: %s", $time, show(got));
				end else begin
					want = tick_outcomes.pop_front();
					if (got !== want) begin
						n_fail++;
						if (n_fail <= 10)
							$display("%t: result %0d differs\n  expected %s\n  actual   %s",
								$time, n_checked, show(want), show(got));
					end
					n_rd   += want.rd_valid;
					n_done += want.done_res;
					n_rej  += want.rejected;
				end
			end
			if (item.valid && item.ready) begin
				rq = {item.req_type, item.reg_addr, item.wr_data, item.buf_index, item.io_in};
				tick_outcomes.push_back(advance_link(rq));
			end
			pending <= tick_outcomes.size();
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the three-wire serial master
// Drives request ticks that walk the block through single and burst accesses
// with refused requests mixed in, stalls both channels at random and leaves
// the prediction and comparison of every result to the link checker.
// ----------------------------------------------------------------------------
module tb;

	// Codes 6 and 7 are not requests; the block must treat them as a tick.
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	// How the data pin is driven during a read.
	localparam int IO_LOW  = 0;
	localparam int IO_HIGH = 1;
	localparam int IO_RAND = 2;

	// Ticks one serial access takes: raise CE, two ticks per bit of the
	// command byte and each data byte, then the tick that drops CE.
	localparam int SINGLE_TICKS = 2 + 16 * 2;
	localparam int BURST_TICKS  = 2 + 16 * (rtc3w_pkg::BURST_BYTES + 1);

	localparam int RANDOM_ITEMS = 1400;
	localparam int IDLE_PCT     = 20;
	// Window, counted in accepted ticks, in which neither side idles.
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1300;
	// The result is registered once, so a short drain covers any stray output.
	localparam int DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	bit          calm;
	int unsigned sent = 0;

	int fail_count;
	int pending;
	int checked;
	int read_bytes;
	int finished;
	int refused;

	rtc3w_req_if item_ch ();
	rtc3w_res_if result_ch ();

	three_wire_rtc_serial_master i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	rtc3w_link_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.read_bytes (read_bytes),
		.finished   (finished),
		.refused    (refused)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Result side: ready drops about one time in five, except in the calm
	// window. It is updated at every edge so stalls land on every tick phase.
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offers one request and returns at the edge where its transaction
	// completes. Random idle cycles come first; during them the payload is
	// scrambled, since the block must ignore it while valid is low. The only
	// assignment to valid in the step of an acceptance is the one made by the
	// next call or by the caller, so valid never bounces within a step.
	task automatic put_item(input logic [2:0] code, input logic [5:0] addr,
		input logic [7:0] data, input logic [2:0] idx, input logic io);
		calm = (sent >= CALM_FROM) && (sent < CALM_TO);
		while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
			item_ch.valid     <= 1'b0;
			item_ch.req_type  <= 3'($urandom);
			item_ch.reg_addr  <= 6'($urandom);
			item_ch.wr_data   <= 8'($urandom);
			item_ch.buf_index <= 3'($urandom);
			item_ch.io_in     <= 1'($urandom);
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.req_type  <= code;
		item_ch.reg_addr  <= addr;
		item_ch.wr_data   <= data;
		item_ch.buf_index <= idx;
		item_ch.io_in     <= io;
		do
			@(posedge clk);
		while (!item_ch.ready);
		sent++;
	endtask

	// Runs one whole serial access: the start request, then plain ticks until
	// CE falls. A share of the middle ticks, given by noise_pct, carries a
	// random request code instead, which the block must refuse while busy.
	// The last tick, the one that drops CE, carries tail_code.
	task automatic run_link(input logic [2:0] code, input logic [5:0] addr,
		input logic [7:0] data, input int io_mode, input int noise_pct,
		input logic [2:0] tail_code);
		int unsigned len;
		logic [2:0]  c;
		logic        io;
		len = (code == rtc3w_pkg::REQ_BWR || code == rtc3w_pkg::REQ_BRD) ?
			BURST_TICKS : SINGLE_TICKS;
		put_item(code, addr, data, 3'($urandom), 1'($urandom));
		for (int k = 1; k < len; k++) begin
			c = rtc3w_pkg::REQ_TICK;
			if (k == len - 1)
				c = tail_code;
			else if ($urandom_range(99) < noise_pct)
				c = 3'($urandom_range(7));
			io = (io_mode == IO_RAND) ? 1'($urandom) : (io_mode == IO_HIGH);
			put_item(c, 6'($urandom), 8'($urandom), 3'($urandom), io);
		end
	endtask

	initial begin
		logic [7:0]  seed_bytes [rtc3w_pkg::BUF_DEPTH];
		int unsigned stop_at;
		int unsigned pick;
		int          noise;
		logic [2:0]  code;
		logic [2:0]  tail;
		seed_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h3C, 8'hC3};

		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.req_type  <= rtc3w_pkg::REQ_TICK;
		item_ch.reg_addr  <= '0;
		item_ch.wr_data   <= '0;
		item_ch.buf_index <= '0;
		item_ch.io_in     <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Idle ticks, including the two spare codes, must do
		// nothing. Every buffer entry is loaded before any burst write, so no
		// burst ever sends an entry that was never written.
		put_item(rtc3w_pkg::REQ_TICK, '0, '0, '0, 1'b0);
		put_item(REQ_SPARE_LO, '1, '1, '1, 1'b1);
		put_item(REQ_SPARE_HI, '0, '1, '0, 1'b1);
		for (int i = 0; i < rtc3w_pkg::BUF_DEPTH; i++)
			put_item(rtc3w_pkg::REQ_LOAD, 6'($urandom), seed_bytes[i], 3'(i), 1'($urandom));

		// Single accesses at both address extremes with all-zero and all-one data.
		run_link(rtc3w_pkg::REQ_SWR, 6'h3F, 8'hFF, IO_LOW, 0, rtc3w_pkg::REQ_TICK);
		run_link(rtc3w_pkg::REQ_SWR, 6'h00, 8'h00, IO_HIGH, 0, rtc3w_pkg::REQ_TICK);
		// A start request on the tick that drops CE must still be refused.
		run_link(rtc3w_pkg::REQ_SRD, 6'h00, 8'h00, IO_HIGH, 0, rtc3w_pkg::REQ_BWR);
		run_link(rtc3w_pkg::REQ_SRD, 6'h3F, 8'hFF, IO_LOW, 0, rtc3w_pkg::REQ_TICK);
		// Bursts with refused starts and loads scattered through them; the
		// load on the final tick must not touch the buffer.
		run_link(rtc3w_pkg::REQ_BWR, 6'h00, 8'h00, IO_RAND, 10, rtc3w_pkg::REQ_LOAD);
		run_link(rtc3w_pkg::REQ_BRD, 6'h3F, 8'hFF, IO_RAND, 10, rtc3w_pkg::REQ_TICK);

		// Random part: mostly complete serial accesses with random content,
		// some of them sprinkled with refused requests, between short runs of
		// idle noise (ticks, spare codes and buffer loads).
		stop_at = sent + RANDOM_ITEMS;
		while (sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				repeat ($urandom_range(4, 1)) begin
					case ($urandom_range(3))
						0:       code = rtc3w_pkg::REQ_TICK;
						1:       code = rtc3w_pkg::REQ_LOAD;
						2:       code = REQ_SPARE_LO;
						default: code = REQ_SPARE_HI;
					endcase
					put_item(code, 6'($urandom), 8'($urandom), 3'($urandom),
						1'($urandom));
				end
			end else begin
				code  = (pick < 50) ? rtc3w_pkg::REQ_SWR :
					(pick < 80) ? rtc3w_pkg::REQ_SRD :
					(pick < 90) ? rtc3w_pkg::REQ_BWR : rtc3w_pkg::REQ_BRD;
				noise = ($urandom_range(1) == 0) ? 0 : 8;
				tail  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 1)) :
					rtc3w_pkg::REQ_TICK;
				run_link(code, 6'($urandom), 8'($urandom), IO_RAND, noise, tail);
			end
		end

		// Drain: the checker's count of open expectations is registered, so the
		// next edge passes before it is read.
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d ticks sent, %0d results checked, %0d serial accesses ended,",
			sent, checked, finished);
		$display("         %0d read bytes seen, %0d busy requests refused, %0d failures.",
			read_bytes, refused, fail_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
